// ===== sv/assert_macros.svh =====
// assertion macros for the timeline block
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/rtw_pkg.sv =====
// types, codes and saturation helpers for relative_timeline_wrap
// no dependencies
package rtw_pkg;

  localparam int TIME_BITS = 32;
  localparam int DUR_W     = TIME_BITS - 1;
  localparam int FACT_W    = 16;
  localparam int FRAC_BITS = 8;
  localparam int ADD_W     = TIME_BITS + 2;
  localparam int DIV_W     = TIME_BITS + 1;
  localparam int PROD_W    = TIME_BITS + FACT_W;
  localparam int CNT_W     = $clog2(TIME_BITS);

  typedef logic signed [TIME_BITS-1:0] time_t;
  typedef logic signed [ADD_W-1:0]     add_t;
  typedef logic signed [PROD_W-1:0]    prod_t;

  localparam time_t TIME_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};
  localparam time_t TIME_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_PAUSE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_DURATION  = 2'd0,
    CFG_SPEED     = 2'd1,
    CFG_PRE_WRAP  = 2'd2,
    CFG_POST_WRAP = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    WRAP_CLAMP  = 2'd0,
    WRAP_REPEAT = 2'd1,
    WRAP_MIRROR = 2'd2
  } wrap_e;

  localparam logic [1:0] WRAP_CODE_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    FIX_NONE = 2'd0,
    FIX_NEG  = 2'd1,
    FIX_TRI  = 2'd2
  } fix_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SUB   = 9'b000000010,
    S_ADD   = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_SCALE = 9'b000010000,
    S_FOLD  = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_FIX   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  // saturate an adder result to the time range
  function automatic time_t sat_time(input add_t v);
    logic ok;
    ok = (&v[ADD_W-1:TIME_BITS-1]) | ~(|v[ADD_W-1:TIME_BITS-1]);
    if (ok) begin
      return v[TIME_BITS-1:0];
    end
    return v[ADD_W-1] ? TIME_MIN : TIME_MAX;
  endfunction

  // floor(product / 2^FRAC_BITS), saturated to the time range
  function automatic time_t sat_scaled(input prod_t p);
    logic ok;
    ok = (&p[PROD_W-1:FRAC_BITS+TIME_BITS-1]) | ~(|p[PROD_W-1:FRAC_BITS+TIME_BITS-1]);
    if (ok) begin
      return p[FRAC_BITS+TIME_BITS-1:FRAC_BITS];
    end
    return p[PROD_W-1] ? TIME_MIN : TIME_MAX;
  endfunction

endpackage

// ===== sv/relative_timeline_wrap.sv =====
// timeline block: local time from parent time with scaling and wrap modes
// depends on rtw_pkg and assert_macros.svh
`include "assert_macros.svh"

//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------
//  in      | input     | in_valid_i / in_ready_o   | cmd_i, parent_time_i, parent_present_i
//  out     | output    | out_valid_o / out_ready_i | local_time_o, is_paused_o, is_started_o
//  cfg     | input     | cfg_we_i                  | cfg_index_i, cfg_data_i
//
//  one item at a time: in_ready_o is high only while the sequencer is idle
//  stop, pause, start and plain ticks go from accept straight to done
//  a paused tick steps through accept, subtract, add and done
//  a running tick: accept, subtract, multiply, scale, fold, done; fold repeats after a
//  reflection; a remainder adds 32 restoring steps on the shared adder, then one fix-up
//  a result waiting on out_ready_i holds the sequencer in its done state
//  reset sets control, timeline and configuration state at once; no clearing pass

module relative_timeline_wrap (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        cmd_i,
  input  logic signed [rtw_pkg::TIME_BITS-1:0] parent_time_i,
  input  logic                              parent_present_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [rtw_pkg::TIME_BITS-1:0] local_time_o,
  output logic                              is_paused_o,
  output logic                              is_started_o,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [rtw_pkg::DUR_W-1:0]         cfg_data_i
);

  // configuration registers
  logic [rtw_pkg::DUR_W-1:0]         dur_q;
  logic signed [rtw_pkg::FACT_W-1:0] speed_q;
  rtw_pkg::wrap_e                    pre_q, post_q;

  // timeline state
  rtw_pkg::time_t off_q, off_d;
  rtw_pkg::time_t cur_q, cur_d;
  logic           paused_q, paused_d;
  logic           started_q, started_d;

  // sequencer and working registers
  rtw_pkg::state_e             state_q, state_d;
  logic [rtw_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  rtw_pkg::time_t              parent_q, parent_d;
  rtw_pkg::time_t              sub_b_q, sub_b_d;
  logic                        adj_q, adj_d;     // paused tick: offset adjust path
  rtw_pkg::time_t              acc_q, acc_d;     // local time being folded
  rtw_pkg::prod_t              prod_q, prod_d;
  logic [rtw_pkg::TIME_BITS-1:0] m_q, m_d;       // dividend, shifted out msb first
  logic [rtw_pkg::TIME_BITS-1:0] rem_q, rem_d;   // partial remainder
  logic [rtw_pkg::DIV_W-1:0]   div_q, div_d;     // divisor: d or 2d
  rtw_pkg::fix_e               fix_q, fix_d;

  // output register
  logic           out_valid_q, out_valid_d;
  rtw_pkg::time_t out_time_q, out_time_d;
  logic           out_paused_q, out_paused_d;
  logic           out_started_q, out_started_d;

  // the one shared adder/subtractor
  rtw_pkg::add_t add_a, add_b, add_y;
  logic          add_sub;
  assign add_y = add_a + (add_sub ? ~add_b : add_b) + rtw_pkg::add_t'(add_sub);

  // fold decisions
  logic                          acc_gt_d;
  logic                          acc_neg;
  logic [rtw_pkg::TIME_BITS-1:0] two_d;
  logic [rtw_pkg::TIME_BITS:0]   div_shift;
  assign acc_gt_d  = $signed(acc_q) > $signed({1'b0, dur_q});
  assign acc_neg   = acc_q[rtw_pkg::TIME_BITS-1];
  assign two_d     = {dur_q, 1'b0};
  assign div_shift = {rem_q, m_q[rtw_pkg::TIME_BITS-1]};

  assign in_ready_o   = (state_q == rtw_pkg::S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign local_time_o = out_time_q;
  assign is_paused_o  = out_paused_q;
  assign is_started_o = out_started_q;

  // sign and zero extension into the adder width
  function automatic rtw_pkg::add_t sx(input rtw_pkg::time_t v);
    return {{(rtw_pkg::ADD_W-rtw_pkg::TIME_BITS){v[rtw_pkg::TIME_BITS-1]}}, v};
  endfunction

  function automatic rtw_pkg::add_t zx(input logic [rtw_pkg::DIV_W-1:0] v);
    return {{(rtw_pkg::ADD_W-rtw_pkg::DIV_W){1'b0}}, v};
  endfunction

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    parent_d      = parent_q;
    sub_b_d       = sub_b_q;
    adj_d         = adj_q;
    acc_d         = acc_q;
    prod_d        = prod_q;
    m_d           = m_q;
    rem_d         = rem_q;
    div_d         = div_q;
    fix_d         = fix_q;
    off_d         = off_q;
    cur_d         = cur_q;
    paused_d      = paused_q;
    started_d     = started_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    out_time_d    = out_time_q;
    out_paused_d  = out_paused_q;
    out_started_d = out_started_q;
    add_a         = '0;
    add_b         = '0;
    add_sub       = 1'b0;

    unique case (state_q)
      rtw_pkg::S_IDLE: begin
        if (in_valid_i) begin
          parent_d = parent_time_i;
          state_d  = rtw_pkg::S_DONE;
          unique case (rtw_pkg::cmd_e'(cmd_i))
            rtw_pkg::CMD_TICK: begin
              if (!parent_present_i) begin
                cur_d = '0;
              end else if (started_q && !paused_q) begin
                sub_b_d = off_q;
                adj_d   = 1'b0;
                state_d = rtw_pkg::S_SUB;
              end else if (paused_q) begin
                sub_b_d = cur_q;
                adj_d   = 1'b1;
                state_d = rtw_pkg::S_SUB;
              end
            end
            rtw_pkg::CMD_START: begin
              if (paused_q) begin
                paused_d = 1'b0;
              end else if (parent_present_i) begin
                // elapsed time is zero right after the offset is latched
                off_d     = parent_time_i;
                cur_d     = '0;
                started_d = 1'b1;
              end
            end
            rtw_pkg::CMD_STOP: begin
              started_d = 1'b0;
              paused_d  = 1'b0;
              cur_d     = '0;
            end
            rtw_pkg::CMD_PAUSE: begin
              paused_d = 1'b1;
            end
            default: begin
              state_d = rtw_pkg::S_DONE;
            end
          endcase
        end
      end

      rtw_pkg::S_SUB: begin
        add_a   = sx(parent_q);
        add_b   = sx(sub_b_q);
        add_sub = 1'b1;
        acc_d   = rtw_pkg::sat_time(add_y);
        state_d = adj_q ? rtw_pkg::S_ADD : rtw_pkg::S_MUL;
      end

      rtw_pkg::S_ADD: begin
        add_a   = sx(off_q);
        add_b   = sx(acc_q);
        off_d   = rtw_pkg::sat_time(add_y);
        state_d = rtw_pkg::S_DONE;
      end

      rtw_pkg::S_MUL: begin
        prod_d  = $signed(acc_q) * speed_q;
        state_d = rtw_pkg::S_SCALE;
      end

      rtw_pkg::S_SCALE: begin
        acc_d   = rtw_pkg::sat_scaled(prod_q);
        state_d = rtw_pkg::S_FOLD;
      end

      rtw_pkg::S_FOLD: begin
        // adder gives 2d - e for a single upper reflection, else -e
        add_sub = 1'b1;
        add_b   = sx(acc_q);
        if (acc_gt_d && post_q == rtw_pkg::WRAP_MIRROR && pre_q != rtw_pkg::WRAP_MIRROR) begin
          add_a = zx({1'b0, two_d});
        end
        cnt_d = rtw_pkg::CNT_W'(rtw_pkg::TIME_BITS - 1);
        rem_d = '0;
        if (acc_gt_d) begin
          if (post_q == rtw_pkg::WRAP_REPEAT) begin
            m_d     = acc_q;
            div_d   = {2'b00, dur_q};
            fix_d   = rtw_pkg::FIX_NONE;
            state_d = rtw_pkg::S_DIV;
          end else if (post_q == rtw_pkg::WRAP_MIRROR && pre_q == rtw_pkg::WRAP_MIRROR) begin
            m_d     = acc_q;
            div_d   = {1'b0, two_d};
            fix_d   = rtw_pkg::FIX_TRI;
            state_d = rtw_pkg::S_DIV;
          end else if (post_q == rtw_pkg::WRAP_MIRROR) begin
            acc_d = add_y[rtw_pkg::TIME_BITS-1:0];
          end else begin
            cur_d   = {1'b0, dur_q};
            state_d = rtw_pkg::S_DONE;
          end
        end else if (acc_neg) begin
          if (pre_q == rtw_pkg::WRAP_REPEAT) begin
            m_d     = add_y[rtw_pkg::TIME_BITS-1:0];
            div_d   = {2'b00, dur_q};
            fix_d   = rtw_pkg::FIX_NEG;
            state_d = rtw_pkg::S_DIV;
          end else if (pre_q == rtw_pkg::WRAP_MIRROR && post_q == rtw_pkg::WRAP_MIRROR) begin
            m_d     = add_y[rtw_pkg::TIME_BITS-1:0];
            div_d   = {1'b0, two_d};
            fix_d   = rtw_pkg::FIX_TRI;
            state_d = rtw_pkg::S_DIV;
          end else if (pre_q == rtw_pkg::WRAP_MIRROR) begin
            // negating the most negative time saturates
            acc_d = (acc_q == rtw_pkg::TIME_MIN) ? rtw_pkg::TIME_MAX
                                                 : add_y[rtw_pkg::TIME_BITS-1:0];
          end else begin
            cur_d   = '0;
            state_d = rtw_pkg::S_DONE;
          end
        end else begin
          cur_d   = acc_q;
          state_d = rtw_pkg::S_DONE;
        end
      end

      rtw_pkg::S_DIV: begin
        // restoring remainder step
        add_a   = zx(div_shift);
        add_b   = zx(div_q);
        add_sub = 1'b1;
        rem_d   = add_y[rtw_pkg::ADD_W-1] ? div_shift[rtw_pkg::TIME_BITS-1:0]
                                          : add_y[rtw_pkg::TIME_BITS-1:0];
        m_d     = {m_q[rtw_pkg::TIME_BITS-2:0], 1'b0};
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = rtw_pkg::S_FIX;
        end
      end

      rtw_pkg::S_FIX: begin
        add_sub = 1'b1;
        add_b   = zx({1'b0, rem_q});
        state_d = rtw_pkg::S_DONE;
        case (fix_q)
          rtw_pkg::FIX_NEG: begin
            add_a = zx({2'b00, dur_q});
            cur_d = (rem_q == '0) ? '0 : add_y[rtw_pkg::TIME_BITS-1:0];
          end
          rtw_pkg::FIX_TRI: begin
            add_a = zx(div_q);
            cur_d = (rem_q > {1'b0, dur_q}) ? add_y[rtw_pkg::TIME_BITS-1:0] : rem_q;
          end
          default: begin
            cur_d = rem_q;
          end
        endcase
      end

      rtw_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_time_d    = cur_q;
          out_paused_d  = paused_q;
          out_started_d = started_q;
          state_d       = rtw_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = rtw_pkg::S_IDLE;
      end
    endcase
  end

  // control and timeline state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rtw_pkg::S_IDLE;
      cnt_q       <= '0;
      off_q       <= '0;
      cur_q       <= '0;
      paused_q    <= 1'b0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      off_q       <= off_d;
      cur_q       <= cur_d;
      paused_q    <= paused_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and output payload registers
  always_ff @(posedge clk_i) begin
    parent_q      <= parent_d;
    sub_b_q       <= sub_b_d;
    adj_q         <= adj_d;
    acc_q         <= acc_d;
    prod_q        <= prod_d;
    m_q           <= m_d;
    rem_q         <= rem_d;
    div_q         <= div_d;
    fix_q         <= fix_d;
    out_time_q    <= out_time_d;
    out_paused_q  <= out_paused_d;
    out_started_q <= out_started_d;
  end

  // configuration writes; a zero duration acts as one, wrap code 3 as clamp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q   <= {rtw_pkg::DUR_W{1'b1}};
      speed_q <= rtw_pkg::FACT_W'(1 << rtw_pkg::FRAC_BITS);
      pre_q   <= rtw_pkg::WRAP_CLAMP;
      post_q  <= rtw_pkg::WRAP_CLAMP;
    end else if (cfg_we_i) begin
      unique case (rtw_pkg::cfg_idx_e'(cfg_index_i))
        rtw_pkg::CFG_DURATION: begin
          dur_q <= (cfg_data_i == '0) ? rtw_pkg::DUR_W'(1) : cfg_data_i;
        end
        rtw_pkg::CFG_SPEED: begin
          speed_q <= cfg_data_i[rtw_pkg::FACT_W-1:0];
        end
        rtw_pkg::CFG_PRE_WRAP: begin
          pre_q <= (cfg_data_i[1:0] == rtw_pkg::WRAP_CODE_UNUSED) ? rtw_pkg::WRAP_CLAMP
                                                               : rtw_pkg::wrap_e'(cfg_data_i[1:0]);
        end
        rtw_pkg::CFG_POST_WRAP: begin
          post_q <= (cfg_data_i[1:0] == rtw_pkg::WRAP_CODE_UNUSED) ? rtw_pkg::WRAP_CLAMP
                                                                : rtw_pkg::wrap_e'(cfg_data_i[1:0]);
        end
        default: begin
          dur_q <= dur_q;
        end
      endcase
    end
  end

  // the block is not ready in the cycle after it accepts an item
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // partial remainder stays below the divisor through the iteration
  `ASSERT_IMPLY(a_rem_below_div, clk_i, rst_ni,
                state_q == rtw_pkg::S_DIV || state_q == rtw_pkg::S_FIX,
                {1'b0, rem_q} < div_q)
  // fix-up only ever follows the last division step
  `ASSERT_IMPLY(a_fix_after_div, clk_i, rst_ni, state_q == rtw_pkg::S_FIX,
                $past(state_q) == rtw_pkg::S_DIV && $past(cnt_q) == '0)
  // folded local time is never negative
  `ASSERT_IMPLY(a_local_nonneg, clk_i, rst_ni, out_valid_o,
                !local_time_o[rtw_pkg::TIME_BITS-1])

endmodule
